// ===== rtl/core/multi_pattern_letter_matcher_defines.svh =====
// assertion macros for the multi pattern letter matcher
`ifndef MULTI_PATTERN_LETTER_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_LETTER_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define MPLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MPLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPLM_ASSERT_IMP(lbl, ante, cons, msg)
`define MPLM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mplm_pkg.sv =====
// types, constants and helpers for the multi pattern letter matcher
package mplm_pkg;
  localparam int NODE_CAP  = 4096;
  localparam int NODE_W    = $clog2(NODE_CAP);
  localparam int PAT_CAP   = 64;
  localparam int LETTERS   = 26;
  localparam int CASE_SPAN = 26;
  localparam int ROW       = 2 * CASE_SPAN;
  localparam int COL_W     = 6;

  localparam logic [1:0] FN_PAT_SYM = 2'd0;
  localparam logic [1:0] FN_PAT_END = 2'd1;
  localparam logic [1:0] FN_TXT_SYM = 2'd2;
  localparam logic [1:0] FN_TXT_END = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] symbol;
  } in_t;

  typedef struct packed {
    logic [63:0] found_mask;
    logic [6:0]  pattern_total;
    logic        overflow;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_LD_UPD, ST_EP_UPD, ST_BR_RD, ST_BR_WR, ST_BQ,
    ST_BU_FAIL, ST_BU_MU, ST_BU_MF, ST_BU_MW, ST_BC_RD, ST_BC_WR,
    ST_TX_GO, ST_TX_GW, ST_TX_MW, ST_TX_OR, ST_ET_OUT
  } state_t;

  function automatic logic letter_ok(input logic [5:0] s);
    logic ok;
    if (int'(s) >= ROW) ok = 1'b0;
    else if (int'(s) < CASE_SPAN) ok = int'(s) < LETTERS;
    else ok = (int'(s) - CASE_SPAN) < LETTERS;
    return ok;
  endfunction
endpackage

// ===== rtl/core/multi_pattern_letter_matcher.sv =====
// multi pattern letter matcher: trie load, link build, text scan
//   channel | dir | payload | handshake
//   in_     | in  | in_t    | in_valid / in_stall
//   out_    | out | out_t   | out_valid / out_stall
// pattern symbol: child table read and maybe a new node; pattern end: mask update;
// text symbol: goto then mask read; end of text: clear of the child rows of every used
// node; one read and one write port per table; the first text symbol adds the link build
// after reset a clear pass over the whole child table runs before any transaction is taken
// in_stall is high while busy; a result held by out_stall only delays the next end of text
module multi_pattern_letter_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mplm_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mplm_pkg::out_t     out_data
);
  import mplm_pkg::*;
  `include "multi_pattern_letter_matcher_defines.svh"

  localparam int AW = NODE_W + COL_W;
  localparam logic [NODE_W:0] NODE_TOP = (NODE_W+1)'(NODE_CAP);

  logic [NODE_W-1:0] child_mem [2**AW];
  logic [NODE_W-1:0] goto_mem  [2**AW];
  logic [NODE_W-1:0] fail_mem  [NODE_CAP];
  logic [63:0]       mask_mem  [NODE_CAP];
  logic [NODE_W-1:0] queue_mem [NODE_CAP];

  state_t state_r, state_nxt;
  logic [NODE_W:0]   node_total_r, node_total_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt, tn_r, tn_nxt, u_r, u_nxt, f_r, f_nxt;
  logic [6:0]        pc_r, pc_nxt;
  logic              built_r, built_nxt, ovf_r, ovf_nxt, broken_r, broken_nxt;
  logic [63:0]       found_r, found_nxt, mu_r, mu_nxt;
  logic [NODE_W:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [COL_W-1:0]  c_r, c_nxt, sym_r, sym_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              ch_re, ch_we, gt_re, gt_we, fl_re, fl_we, mk_re, mk_we, q_re, q_we;
  logic [AW-1:0]     ch_ra, ch_wa, gt_ra, gt_wa;
  logic [NODE_W-1:0] ch_wd, gt_wd, fl_ra, fl_wa, fl_wd, mk_ra, mk_wa, q_ra, q_wa, q_wd;
  logic [63:0]       mk_wd;
  logic [NODE_W-1:0] ch_rd, gt_rd, fl_rd, q_rd;
  logic [63:0]       mk_rd;
  logic              accept;
  logic              et_fire;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // end of text may only load the result register once the previous result is gone
  assign et_fire   = (state_r == ST_ET_OUT) && !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (ch_we) child_mem[ch_wa] <= ch_wd;
    if (ch_re) ch_rd <= child_mem[ch_ra];
    if (gt_we) goto_mem[gt_wa] <= gt_wd;
    if (gt_re) gt_rd <= goto_mem[gt_ra];
    if (fl_we) fail_mem[fl_wa] <= fl_wd;
    if (fl_re) fl_rd <= fail_mem[fl_ra];
    if (mk_we) mask_mem[mk_wa] <= mk_wd;
    if (mk_re) mk_rd <= mask_mem[mk_ra];
    if (q_we) queue_mem[q_wa] <= q_wd;
    if (q_re) q_rd <= queue_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      node_total_r <= (NODE_W+1)'(NODE_CAP);
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      cursor_r     <= '0;
      tn_r         <= '0;
      pc_r         <= '0;
      built_r      <= 1'b0;
      ovf_r        <= 1'b0;
      broken_r     <= 1'b0;
      found_r      <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      c_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      node_total_r <= node_total_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      cursor_r     <= cursor_nxt;
      tn_r         <= tn_nxt;
      pc_r         <= pc_nxt;
      built_r      <= built_nxt;
      ovf_r        <= ovf_nxt;
      broken_r     <= broken_nxt;
      found_r      <= found_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      c_r          <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    f_r   <= f_nxt;
    mu_r  <= mu_nxt;
    sym_r <= sym_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;  node_total_nxt = node_total_r;  cnt_nxt = cnt_r;
    cursor_nxt = cursor_r;  tn_nxt = tn_r;  pc_nxt = pc_r;  built_nxt = built_r;
    ovf_nxt = ovf_r;  broken_nxt = broken_r;  found_nxt = found_r;
    head_nxt = head_r;  tail_nxt = tail_r;  c_nxt = c_r;  u_nxt = u_r;  f_nxt = f_r;
    mu_nxt = mu_r;  sym_nxt = sym_r;  out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ch_re = 1'b0; ch_we = 1'b0; ch_ra = '0; ch_wa = '0; ch_wd = '0;
    gt_re = 1'b0; gt_we = 1'b0; gt_ra = '0; gt_wa = '0; gt_wd = '0;
    fl_re = 1'b0; fl_we = 1'b0; fl_ra = '0; fl_wa = '0; fl_wd = '0;
    mk_re = 1'b0; mk_we = 1'b0; mk_ra = '0; mk_wa = '0; mk_wd = '0;
    q_re = 1'b0; q_we = 1'b0; q_ra = '0; q_wa = '0; q_wd = '0;
    case (state_r)
      ST_CLR: begin
        ch_we = 1'b1;
        ch_wa = cnt_r[AW-1:0];
        if (cnt_r[COL_W-1:0] == '0) begin
          mk_we = 1'b1;
          mk_wa = cnt_r[AW-1:COL_W];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt == {node_total_r, {COL_W{1'b0}}}) begin
          node_total_nxt = (NODE_W+1)'(1);
          cursor_nxt = '0;  tn_nxt = '0;  pc_nxt = '0;  built_nxt = 1'b0;
          ovf_nxt = 1'b0;  broken_nxt = 1'b0;  found_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          sym_nxt = in_data.symbol;
          case (in_data.func)
            FN_PAT_SYM: begin
              if (!built_r && !broken_r && letter_ok(in_data.symbol)) begin
                ch_re = 1'b1;
                ch_ra = {cursor_r, in_data.symbol};
                state_nxt = ST_LD_UPD;
              end
            end
            FN_PAT_END: begin
              if (!built_r) begin
                if (int'(pc_r) >= PAT_CAP) begin
                  ovf_nxt = 1'b1;
                  cursor_nxt = '0;
                  broken_nxt = 1'b0;
                end else if (broken_r) begin
                  pc_nxt = pc_r + 1'b1;
                  cursor_nxt = '0;
                  broken_nxt = 1'b0;
                end else begin
                  mk_re = 1'b1;
                  mk_ra = cursor_r;
                  state_nxt = ST_EP_UPD;
                end
              end
            end
            FN_TXT_SYM: begin
              if (!built_r) begin
                c_nxt = '0;  head_nxt = '0;  tail_nxt = '0;
                state_nxt = ST_BR_RD;
              end else begin
                state_nxt = ST_TX_GO;
              end
            end
            default: begin
              mk_re = 1'b1;
              mk_ra = '0;
              state_nxt = ST_ET_OUT;
            end
          endcase
        end
      end
      ST_LD_UPD: begin
        if (ch_rd != '0) begin
          cursor_nxt = ch_rd;
        end else if (int'(node_total_r) >= NODE_CAP) begin
          ovf_nxt = 1'b1;
          broken_nxt = 1'b1;
        end else begin
          ch_we = 1'b1;
          ch_wa = {cursor_r, sym_r};
          ch_wd = node_total_r[NODE_W-1:0];
          cursor_nxt = node_total_r[NODE_W-1:0];
          node_total_nxt = node_total_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_EP_UPD: begin
        mk_we = 1'b1;
        mk_wa = cursor_r;
        mk_wd = mk_rd | (64'd1 << pc_r[5:0]);
        pc_nxt = pc_r + 1'b1;
        cursor_nxt = '0;
        broken_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      ST_BR_RD: begin
        ch_re = 1'b1;
        ch_ra = {{NODE_W{1'b0}}, c_r};
        state_nxt = ST_BR_WR;
      end
      ST_BR_WR: begin
        gt_we = 1'b1;
        gt_wa = {{NODE_W{1'b0}}, c_r};
        gt_wd = ch_rd;
        if (ch_rd != '0 && int'(tail_r) < NODE_CAP) begin
          fl_we = 1'b1;  fl_wa = ch_rd;  fl_wd = '0;
          q_we = 1'b1;  q_wa = tail_r[NODE_W-1:0];  q_wd = ch_rd;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt = c_r + 1'b1;
        state_nxt = (int'(c_r) == ROW - 1) ? ST_BQ : ST_BR_RD;
      end
      ST_BQ: begin
        if (head_r == tail_r) begin
          built_nxt = 1'b1;
          tn_nxt = '0;
          found_nxt = '0;
          state_nxt = ST_TX_GO;
        end else begin
          q_re = 1'b1;
          q_ra = head_r[NODE_W-1:0];
          state_nxt = ST_BU_FAIL;
        end
      end
      ST_BU_FAIL: begin
        u_nxt = q_rd;
        head_nxt = head_r + 1'b1;
        fl_re = 1'b1;
        fl_ra = q_rd;
        state_nxt = ST_BU_MU;
      end
      ST_BU_MU: begin
        f_nxt = fl_rd;
        mk_re = 1'b1;
        mk_ra = u_r;
        state_nxt = ST_BU_MF;
      end
      ST_BU_MF: begin
        mu_nxt = mk_rd;
        mk_re = 1'b1;
        mk_ra = f_r;
        state_nxt = ST_BU_MW;
      end
      ST_BU_MW: begin
        mk_we = 1'b1;
        mk_wa = u_r;
        mk_wd = mu_r | mk_rd;
        c_nxt = '0;
        state_nxt = ST_BC_RD;
      end
      ST_BC_RD: begin
        ch_re = 1'b1;
        ch_ra = {u_r, c_r};
        gt_re = 1'b1;
        gt_ra = {f_r, c_r};
        state_nxt = ST_BC_WR;
      end
      ST_BC_WR: begin
        gt_we = 1'b1;
        gt_wa = {u_r, c_r};
        if (ch_rd != '0) begin
          gt_wd = ch_rd;
          fl_we = 1'b1;  fl_wa = ch_rd;  fl_wd = gt_rd;
          if (int'(tail_r) < NODE_CAP) begin
            q_we = 1'b1;  q_wa = tail_r[NODE_W-1:0];  q_wd = ch_rd;
            tail_nxt = tail_r + 1'b1;
          end
        end else begin
          gt_wd = gt_rd;
        end
        c_nxt = c_r + 1'b1;
        state_nxt = (int'(c_r) == ROW - 1) ? ST_BQ : ST_BC_RD;
      end
      ST_TX_GO: begin
        if (letter_ok(sym_r)) begin
          gt_re = 1'b1;
          gt_ra = {tn_r, sym_r};
          state_nxt = ST_TX_GW;
        end else begin
          tn_nxt = '0;
          state_nxt = ST_TX_MW;
        end
      end
      ST_TX_GW: begin
        tn_nxt = gt_rd;
        state_nxt = ST_TX_MW;
      end
      ST_TX_MW: begin
        mk_re = 1'b1;
        mk_ra = tn_r;
        state_nxt = ST_TX_OR;
      end
      ST_TX_OR: begin
        found_nxt = found_r | mk_rd;
        state_nxt = ST_IDLE;
      end
      ST_ET_OUT: begin
        if (et_fire) begin
          out_nxt.found_mask = found_r | mk_rd;
          out_nxt.pattern_total = pc_r;
          out_nxt.overflow = ovf_r;
          out_valid_nxt = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_CLR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `MPLM_ASSERT_IMP(a_busy_stalls, state_r != ST_IDLE, in_stall, "busy but not stalled")
  `MPLM_ASSERT_IMP(a_node_range, 1'b1, node_total_r != '0 && node_total_r <= NODE_TOP, "bad node count")
  `MPLM_ASSERT_IMP(a_pat_range, 1'b1, int'(pc_r) <= PAT_CAP, "pattern count out of range")
  `MPLM_ASSERT_NXT(a_result_clears, et_fire, out_valid_r && state_r == ST_CLR, "end of text without result")
endmodule

// ===== tb/tb_top.sv =====
// testbench for the multi pattern letter matcher: directed table plus random rounds
`timescale 1ns / 1ps
module tb_top;
  import mplm_pkg::*;

  localparam int NCAP = 4096;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #5 clk = ~clk;

  multi_pattern_letter_matcher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // matcher state kept by the predictor
  int unsigned trie_child [int];
  int unsigned jump_tab [int];
  int unsigned link_of [int];
  logic [63:0] hit_mask [int];
  int unsigned n_nodes, cursor, n_pats, cur_node;
  bit          scanning, ovf, broken;
  logic [63:0] seen_bits;

  out_t found_q[$];
  int   n_bad;
  int   send_idle_pct, recv_stall_pct;

  function automatic bit sym_ok(logic [5:0] s);
    if (s >= 52) return 1'b0;
    if (s < 26) return s < LETTERS;
    return (s - 26) < LETTERS;
  endfunction

  function automatic int unsigned kid(int unsigned n, int unsigned c);
    return trie_child.exists(n * 52 + c) ? trie_child[n * 52 + c] : 0;
  endfunction

  function automatic logic [63:0] mask_of(int unsigned n);
    return hit_mask.exists(n) ? hit_mask[n] : 64'd0;
  endfunction

  task automatic clear_matcher();
    trie_child.delete(); jump_tab.delete(); link_of.delete(); hit_mask.delete();
    n_nodes = 1; cursor = 0; n_pats = 0; cur_node = 0;
    scanning = 0; ovf = 0; broken = 0; seen_bits = '0;
  endtask

  task automatic build_links();
    int unsigned fifo[$];
    int unsigned u, f, v;
    for (int c = 0; c < 52; c++) begin
      v = kid(0, c);
      jump_tab[c] = v;
      if (v != 0) begin
        link_of[v] = 0; fifo.insert(fifo.size(), v);
      end
    end
    while (fifo.size() > 0) begin
      u = fifo.pop_front();
      f = link_of[u];
      hit_mask[u] = mask_of(u) | mask_of(f);
      for (int c = 0; c < 52; c++) begin
        v = kid(u, c);
        if (v != 0) begin
          link_of[v] = jump_tab[f * 52 + c];
          jump_tab[u * 52 + c] = v;
          fifo.insert(fifo.size(), v);
        end else begin
          jump_tab[u * 52 + c] = jump_tab[f * 52 + c];
        end
      end
    end
  endtask

  task automatic predict_match(in_t t);
    out_t r;
    int unsigned v;
    case (t.func)
      FN_PAT_SYM: begin
        if (!scanning && !broken && sym_ok(t.symbol)) begin
          v = kid(cursor, t.symbol);
          if (v == 0) begin
            if (n_nodes >= NCAP) begin
              ovf = 1; broken = 1;
            end else begin
              v = n_nodes++;
              trie_child[cursor * 52 + t.symbol] = v;
            end
          end
          if (!broken) cursor = v;
        end
      end
      FN_PAT_END: begin
        if (!scanning) begin
          if (n_pats >= PAT_CAP) ovf = 1;
          else begin
            if (!broken) hit_mask[cursor] = mask_of(cursor) | (64'd1 << n_pats);
            n_pats++;
          end
          cursor = 0; broken = 0;
        end
      end
      FN_TXT_SYM: begin
        if (!scanning) begin
          build_links(); scanning = 1; cur_node = 0; seen_bits = '0;
        end
        cur_node = sym_ok(t.symbol) ? jump_tab[cur_node * 52 + t.symbol] : 0;
        seen_bits |= mask_of(cur_node);
      end
      default: begin
        r.found_mask = seen_bits | mask_of(0);
        r.pattern_total = 7'(n_pats);
        r.overflow = ovf;
        found_q.insert(found_q.size(), r);
        clear_matcher();
      end
    endcase
  endtask

  // valid stays high between back to back transactions and drops only when idling
  task automatic send(logic [1:0] fn, logic [5:0] s);
    in_t t;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    t.func = fn; t.symbol = s;
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_match(t);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (found_q.size() > 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (found_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected transaction %h", out_data);
      end else begin
        e = found_q.pop_front();
        if (e.found_mask !== out_data.found_mask || e.pattern_total !== out_data.pattern_total
            || e.overflow !== out_data.overflow) begin
          n_bad++;
          if (n_bad <= 10)
            $display("exp mask %h total %0d ovf %0b, got mask %h total %0d ovf %0b",
                     e.found_mask, e.pattern_total, e.overflow, out_data.found_mask,
                     out_data.pattern_total, out_data.overflow);
        end
      end
    end
  end

  always @(negedge clk)
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

  typedef struct {
    logic [1:0] fn;
    logic [5:0] s;
    bit         chk;
    out_t       want;
  } row_t;

  row_t script[$];

  function automatic row_t mk(logic [1:0] fn, logic [5:0] s);
    row_t r;
    r.fn = fn; r.s = s; r.chk = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_end(logic [63:0] m, logic [6:0] n, logic o);
    row_t r;
    r = mk(FN_TXT_END, 6'd0);
    r.chk = 1; r.want.found_mask = m; r.want.pattern_total = n; r.want.overflow = o;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    script.insert(script.size(), r);
  endfunction

  // random round: first words, then text salted with those words
  task automatic random_round(int npat, int maxlen);
    logic [5:0] words[$][$];
    logic [5:0] w[$];
    int len;
    for (int p = 0; p < npat; p++) begin
      w.delete();
      len = $urandom_range(maxlen);
      for (int k = 0; k < len; k++) begin
        w.insert(w.size(), ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                    : 6'($urandom_range(3)));
        send(FN_PAT_SYM, w[k]);
      end
      words.insert(words.size(), w);
      send(FN_PAT_END, 6'($urandom_range(63)));
    end
    len = $urandom_range(30);
    for (int k = 0; k < len; k++) begin
      if (words.size() > 0 && $urandom_range(3) == 0) begin
        w = words[$urandom_range(words.size() - 1)];
        foreach (w[j]) send(FN_TXT_SYM, w[j]);
      end else begin
        send(FN_TXT_SYM, ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(3)));
      end
      if ($urandom_range(30) == 0) send(FN_PAT_SYM, 6'($urandom_range(51)));
    end
    send(FN_TXT_END, 6'($urandom_range(63)));
  endtask

  initial begin
    #100_000_000;
    $display("multi_pattern_letter_matcher: mismatch");
    $finish;
  end

  initial begin
    row_t r;
    out_t got;
    n_bad = 0; send_idle_pct = 0; recv_stall_pct = 0;
    clear_matcher();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    add_row(mk_end(64'd0, 7'd0, 1'b0));
    add_row(mk(FN_PAT_END, 6'd63));
    add_row(mk_end(64'd1, 7'd1, 1'b0));
    add_row(mk(FN_PAT_SYM, 6'd0));
    add_row(mk(FN_PAT_SYM, 6'd51));
    add_row(mk(FN_PAT_SYM, 6'd52));
    add_row(mk(FN_PAT_SYM, 6'd63));
    add_row(mk(FN_PAT_END, 6'd0));
    add_row(mk(FN_PAT_SYM, 6'd51));
    add_row(mk(FN_PAT_END, 6'd0));
    add_row(mk(FN_TXT_SYM, 6'd0));
    add_row(mk(FN_TXT_SYM, 6'd51));
    add_row(mk(FN_PAT_SYM, 6'd25));
    add_row(mk(FN_PAT_END, 6'd0));
    add_row(mk(FN_TXT_SYM, 6'd63));
    add_row(mk(FN_TXT_SYM, 6'd51));
    add_row(mk_end(64'd3, 7'd2, 1'b0));
    add_row(mk(FN_PAT_SYM, 6'd26));
    add_row(mk(FN_PAT_END, 6'd0));
    add_row(mk(FN_TXT_SYM, 6'd42));
    add_row(mk_end(64'd0, 7'd1, 1'b0));
    foreach (script[i]) begin
      r = script[i];
      send(r.fn, r.s);
      if (r.chk) begin
        got = found_q[$];
        if (got != r.want) begin
          n_bad++;
          if (n_bad <= 10) $display("row %0d: exp %h got %h", i, r.want, got);
        end
      end
    end

    // pattern capacity: 66 empty patterns
    repeat (66) send(FN_PAT_END, 6'd0);
    send(FN_TXT_END, 6'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 17 : 0;
      recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 17 : 0;
      for (int k = 0; k < 8; k++) random_round($urandom_range(6), 4);
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    random_round(70, 3);
    drain();

    if (n_bad == 0 && found_q.size() == 0)
      $display("multi_pattern_letter_matcher: match");
    else
      $display("multi_pattern_letter_matcher: mismatch");
    $finish;
  end
endmodule
